### hw/rtl/quaternion_rotate_vector_defines.svh
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_defines.svh
// assertion macros shared by the rotation block
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define QRV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("qrv assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define QRV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrv assertion failed");

`else

`define QRV_ASSERT_IMP(label, ante, cons)
`define QRV_ASSERT_NXT(label, ante, cons)

`endif

`endif

### hw/rtl/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg
// shared constants for the quaternion vector rotation block
// ----------------------------------------------------------------------------
package qrv_pkg;

    // quaternion components are fixed at 16 bits
    localparam int QUAT_WIDTH = 16;

    // default vector width and quaternion fraction bits
    localparam int VEC_WIDTH_DEF      = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // pipeline depth from start to done
    localparam int LATENCY = 5;

endpackage

### hw/rtl/quaternion_rotate_vector.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// rotates a vector by a quaternion, r = q * (v,0) * conj(q), in fixed point
// ----------------------------------------------------------------------------
// A beat is taken on every cycle that start is high; busy is always low, so a
// new item may be issued each clock. Each result appears on rot_x/rot_y/rot_z
// and clipped for exactly one cycle with done high, in issue order. The
// receiver cannot stall. The datapath is built from the
// five register stages: the q*v products, the first Hamilton sum, the p*q
// products, the second Hamilton sum, and the round-and-saturate output. All
// products are exact; each component is rounded half up, shifted right by
// 2*QUAT_FRAC_BITS and saturated to VEC_WIDTH bits, with clipped set when any
// component saturated. The quaternion is not normalized; a non-unit input
// scales the result by |q|^2.
`include "quaternion_rotate_vector_defines.svh"

module quaternion_rotate_vector #(
    parameter int VEC_WIDTH      = qrv_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] quat_x,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] quat_y,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] quat_z,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] quat_w,
    input  logic signed [VEC_WIDTH-1:0]          vec_x,
    input  logic signed [VEC_WIDTH-1:0]          vec_y,
    input  logic signed [VEC_WIDTH-1:0]          vec_z,
    output logic                                 done,
    output logic signed [VEC_WIDTH-1:0]          rot_x,
    output logic signed [VEC_WIDTH-1:0]          rot_y,
    output logic signed [VEC_WIDTH-1:0]          rot_z,
    output logic                                 clipped
);

    localparam int QW  = qrv_pkg::QUAT_WIDTH;
    localparam int LAT = qrv_pkg::LATENCY;
    localparam int M1W = QW + VEC_WIDTH;          // q*v product
    localparam int PW  = M1W + 2;                 // sum of three products
    localparam int M2W = PW + QW;                 // p*q product
    localparam int RW  = M2W + 2;                 // sum of four products
    localparam int SH  = 2 * QUAT_FRAC_BITS;
    localparam int AW  = ((RW > SH + 1) ? RW : SH + 1) + 1;

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SH - 1);
    localparam logic signed [AW-1:0] MAXV = (AW'(1) <<< (VEC_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] MINV = -MAXV - AW'(1);

    // round half up, shift and saturate; msb of the result is the clip flag
    function automatic logic [VEC_WIDTH:0] round_sat(input logic signed [RW-1:0] r);
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] shv;
        logic [VEC_WIDTH:0]   res;
        acc = AW'(r) + HALF;
        shv = acc >>> SH;
        if (shv > MAXV) begin
            res = {1'b1, MAXV[VEC_WIDTH-1:0]};
        end
        else if (shv < MINV) begin
            res = {1'b1, MINV[VEC_WIDTH-1:0]};
        end
        else begin
            res = {1'b0, shv[VEC_WIDTH-1:0]};
        end
        return res;
    endfunction

    // valid bits travel alongside the data
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    // stage 1: q*v products and quaternion copy
    logic signed [M1W-1:0] m1_reg [12];
    logic signed [M1W-1:0] m1_next [12];
    logic signed [QW-1:0]  q1_reg [4];

    // stage 2: p = q*(v,0) and quaternion copy
    logic signed [PW-1:0]  pw_reg, px_reg, py_reg, pz_reg;
    logic signed [PW-1:0]  pw_next, px_next, py_next, pz_next;
    logic signed [QW-1:0]  q2_reg [4];

    // stage 3: p*conj(q) products
    logic signed [M2W-1:0] m2_reg [12];
    logic signed [M2W-1:0] m2_next [12];

    // stage 4: r sums
    logic signed [RW-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [RW-1:0]  rx_next, ry_next, rz_next;

    // stage 5: rounded, saturated output
    logic signed [VEC_WIDTH-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic [VEC_WIDTH:0]          sat_x, sat_y, sat_z;
    logic                        clip_reg;
    logic                        clip_next;

    // every beat is taken: the pipeline never holds
    assign busy = 1'b0;
    assign valid_next = {valid_reg[LAT-2:0], start};

    // q*v products; quaternion index 0..3 is x, y, z, w
    always_comb
    begin
        m1_next[0]  = M1W'(quat_x) * M1W'(vec_x);
        m1_next[1]  = M1W'(quat_y) * M1W'(vec_y);
        m1_next[2]  = M1W'(quat_z) * M1W'(vec_z);
        m1_next[3]  = M1W'(quat_w) * M1W'(vec_x);
        m1_next[4]  = M1W'(quat_y) * M1W'(vec_z);
        m1_next[5]  = M1W'(quat_z) * M1W'(vec_y);
        m1_next[6]  = M1W'(quat_w) * M1W'(vec_y);
        m1_next[7]  = M1W'(quat_z) * M1W'(vec_x);
        m1_next[8]  = M1W'(quat_x) * M1W'(vec_z);
        m1_next[9]  = M1W'(quat_w) * M1W'(vec_z);
        m1_next[10] = M1W'(quat_x) * M1W'(vec_y);
        m1_next[11] = M1W'(quat_y) * M1W'(vec_x);
    end

    // first hamilton product, scalar and vector parts
    always_comb
    begin
        pw_next = -PW'(m1_reg[0]) - PW'(m1_reg[1]) - PW'(m1_reg[2]);
        px_next =  PW'(m1_reg[3]) + PW'(m1_reg[4]) - PW'(m1_reg[5]);
        py_next =  PW'(m1_reg[6]) + PW'(m1_reg[7]) - PW'(m1_reg[8]);
        pz_next =  PW'(m1_reg[9]) + PW'(m1_reg[10]) - PW'(m1_reg[11]);
    end

    // p times conjugate quaternion, products
    always_comb
    begin
        m2_next[0]  = M2W'(px_reg) * M2W'(q2_reg[3]);
        m2_next[1]  = M2W'(pw_reg) * M2W'(q2_reg[0]);
        m2_next[2]  = M2W'(pz_reg) * M2W'(q2_reg[1]);
        m2_next[3]  = M2W'(py_reg) * M2W'(q2_reg[2]);
        m2_next[4]  = M2W'(py_reg) * M2W'(q2_reg[3]);
        m2_next[5]  = M2W'(pw_reg) * M2W'(q2_reg[1]);
        m2_next[6]  = M2W'(px_reg) * M2W'(q2_reg[2]);
        m2_next[7]  = M2W'(pz_reg) * M2W'(q2_reg[0]);
        m2_next[8]  = M2W'(pz_reg) * M2W'(q2_reg[3]);
        m2_next[9]  = M2W'(pw_reg) * M2W'(q2_reg[2]);
        m2_next[10] = M2W'(py_reg) * M2W'(q2_reg[0]);
        m2_next[11] = M2W'(px_reg) * M2W'(q2_reg[1]);
    end

    // vector part of the second product
    always_comb
    begin
        rx_next = RW'(m2_reg[0]) - RW'(m2_reg[1]) + RW'(m2_reg[2])  - RW'(m2_reg[3]);
        ry_next = RW'(m2_reg[4]) - RW'(m2_reg[5]) + RW'(m2_reg[6])  - RW'(m2_reg[7]);
        rz_next = RW'(m2_reg[8]) - RW'(m2_reg[9]) + RW'(m2_reg[10]) - RW'(m2_reg[11]);
    end

    // rounding and saturation
    always_comb
    begin
        sat_x     = round_sat(rx_reg);
        sat_y     = round_sat(ry_reg);
        sat_z     = round_sat(rz_reg);
        clip_next = sat_x[VEC_WIDTH] | sat_y[VEC_WIDTH] | sat_z[VEC_WIDTH];
    end

    // control: valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        m1_reg    <= m1_next;
        q1_reg[0] <= quat_x;
        q1_reg[1] <= quat_y;
        q1_reg[2] <= quat_z;
        q1_reg[3] <= quat_w;
        pw_reg    <= pw_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        q2_reg    <= q1_reg;
        m2_reg    <= m2_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        rz_reg    <= rz_next;
        rot_x_reg <= sat_x[VEC_WIDTH-1:0];
        rot_y_reg <= sat_y[VEC_WIDTH-1:0];
        rot_z_reg <= sat_z[VEC_WIDTH-1:0];
        clip_reg  <= clip_next;
    end

    // result beat
    assign done    = valid_reg[LAT-1];
    assign rot_x   = rot_x_reg;
    assign rot_y   = rot_y_reg;
    assign rot_z   = rot_z_reg;
    assign clipped = clip_reg;

    // each start beat yields a result beat at the end of the pipeline
    `QRV_ASSERT_IMP(a_start_to_done, start, ##LAT done)

    // a clipped result carries at least one rail value
    `QRV_ASSERT_IMP(a_clip_rail, done && clipped,
        (rot_x == MAXV[VEC_WIDTH-1:0] || rot_x == MINV[VEC_WIDTH-1:0] ||
         rot_y == MAXV[VEC_WIDTH-1:0] || rot_y == MINV[VEC_WIDTH-1:0] ||
         rot_z == MAXV[VEC_WIDTH-1:0] || rot_z == MINV[VEC_WIDTH-1:0]))

    // no result beat without a start beat the matching number of cycles back
    `QRV_ASSERT_NXT(a_no_spurious, !valid_reg[LAT-2], !done)

endmodule
